// ===== rtl/tap_pkg.sv =====
`default_nettype none

package tap_pkg;

  // Fixed geometry of the translation scheme.
  localparam int NUM_SPACES  = 256;
  localparam int OFFSET_BITS = 12;
  localparam int SPACE_BITS  = 8;
  localparam int CFG_BITS    = 11;
  localparam int PIN_BITS    = 16;
  localparam int PA_BITS     = 22;
  localparam int FRAME_OUT_BITS = 10;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1024;
  localparam logic [PIN_BITS-1:0] PIN_MAX   = 16'hFFFF;

  // Request operations.
  typedef enum logic [2:0] {
    OP_TRANSLATE = 3'd0,
    OP_FLUSH_ENTRY = 3'd1,
    OP_FLUSH_ALL = 3'd2,
    OP_SWITCH = 3'd3,
    OP_PIN = 3'd4,
    OP_UNPIN = 3'd5,
    OP_ALLOCATE = 3'd6
  } op_t;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_TLB_FULL  = 3'd2;
  localparam logic [2:0] ST_NO_MEMORY = 3'd3;
  localparam logic [2:0] ST_NO_ENTRY  = 3'd4;
  localparam logic [2:0] ST_UNPINNED  = 3'd5;
  localparam logic [2:0] ST_BAD_FRAME = 3'd6;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_SCAN,
    S_PIN,
    S_SWITCH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/tlb_asid_page_allocator.sv =====
`default_nettype none

// Translation buffer with address space tags, page tables and a pinned frame pool.
// Requests enter on in_* when start is high and busy is low; one result per
// request appears on out_* for exactly one cycle, marked by out_valid. The
// receiver cannot hold results off, and busy stays high until the result shows.
// Path of each request: flush entry, flush all, the unused code, pin or unpin of a
// bad frame and translate hits give their result from S_DECODE; pin and unpin go on
// to S_PIN, switch process to S_SWITCH and a translate miss on a present page to
// S_WALK. An allocation scans the pin count memory one frame per cycle from frame 0
// in S_SCAN, and a miss on an absent page goes from S_WALK into that scan; it ends at
// the first free frame, or at the effective frame count when none is free, and reads
// through the single pin count read port. busy drops in the result cycle, so the
// next request can be taken as the result leaves.
// After reset the block clears the page table, pin count and process memories
// one entry per cycle, over every entry up to the larger of the page table depth
// (256 << PAGE_NUMBER_BITS) and FRAMES. busy is high during that pass; configuration
// writes on cfg_* are taken whenever the block is idle, and cfg_ready shows when.
module tlb_asid_page_allocator #(
  parameter int TLB_ENTRIES      = 64,
  parameter int FRAMES           = 1024,
  parameter int PAGE_NUMBER_BITS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic [17:0] in_virtual_address,
  input  wire logic [7:0]  in_asid,
  input  wire logic [7:0]  in_process_id,
  input  wire logic [9:0]  in_frame_number,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [21:0]      out_physical_address,
  output logic [9:0]       out_allocated_frame,
  output logic [15:0]      out_pin_count_out,
  output logic [7:0]       out_current_asid_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [tap_pkg::CFG_BITS-1:0] cfg_data
);
  import tap_pkg::*;

  localparam int PB = PAGE_NUMBER_BITS;
  localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int FW = $clog2(FRAMES);
  localparam int CW = ($clog2(FRAMES + 1) > CFG_BITS) ? $clog2(FRAMES + 1) : CFG_BITS;
  localparam int TIW = SPACE_BITS + PB;
  localparam int TABLE_DEPTH = NUM_SPACES << PB;
  localparam int CLR_DEPTH = (TABLE_DEPTH > FRAMES) ? TABLE_DEPTH : FRAMES;
  localparam int CLRW = $clog2(CLR_DEPTH);
  localparam int VW = OFFSET_BITS + PB + 18;

  // Sequencer and request registers.
  state_t state_r, state_nxt;
  logic [2:0]             op_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [PB-1:0]          vpn_r;
  logic [SPACE_BITS-1:0]  asid_r;
  logic [SPACE_BITS-1:0]  pid_r;
  logic [9:0]             fr_r;
  logic [CFG_BITS-1:0]    cfg_r;
  logic [CLRW-1:0]        clr_r;
  logic [SPACE_BITS-1:0]  next_id_r, next_id_nxt;
  logic [SPACE_BITS-1:0]  cur_id_r, cur_id_nxt;

  // Translation buffer entries.
  logic [PB-1:0]         tlb_tag_r   [TLB_ENTRIES];
  logic [FW-1:0]         tlb_frame_r [TLB_ENTRIES];
  logic [SPACE_BITS-1:0] tlb_space_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_r;

  // Memories.
  logic [FW:0]           pt_mem   [TABLE_DEPTH];
  logic [PIN_BITS-1:0]   pin_mem  [FRAMES];
  logic [SPACE_BITS-1:0] proc_mem [NUM_SPACES];
  logic [FW:0]           pt_rdata_r;
  logic [PIN_BITS-1:0]   pin_rdata_r;
  logic [SPACE_BITS-1:0] proc_rdata_r;

  logic pt_we, pt_re, pin_we, pin_re, proc_we, proc_re;
  logic [TIW-1:0]        pt_waddr, pt_raddr;
  logic [FW:0]           pt_wdata;
  logic [FW-1:0]         pin_waddr, pin_raddr;
  logic [PIN_BITS-1:0]   pin_wdata;
  logic [SPACE_BITS-1:0] proc_waddr, proc_raddr, proc_wdata;

  // Frame scan registers.
  logic [CW-1:0] scan_addr_r, scan_rd_r;
  logic          scan_pend_r;
  logic          scan_start, scan_issue;

  // Result registers.
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [PA_BITS-1:0] out_pa_r;
  logic [9:0]        out_alloc_r;
  logic [PIN_BITS-1:0] out_pins_r;
  logic [SPACE_BITS-1:0] out_asid_r;

  logic              res_en;
  logic [2:0]        res_status;
  logic [PA_BITS-1:0] res_pa;
  logic [9:0]        res_alloc;
  logic [PIN_BITS-1:0] res_pins;

  // Buffer update controls.
  logic          inval_all, inval_en, fill_en;
  logic [TW-1:0] inval_idx;
  logic [FW-1:0] fill_frame;

  // Search results.
  logic          hit_any, match_any, free_any;
  logic [TW-1:0] hit_idx, match_idx, free_idx;

  logic [VW-1:0] va_ext;
  logic [CW-1:0] eff;
  logic          fr_bad, scan_found, scan_fail, clr_last;
  logic [CW-1:0] fr_ext;
  logic [TIW-1:0] pt_idx;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign va_ext    = VW'(in_virtual_address);
  assign eff       = ({{(CW-CFG_BITS){1'b0}}, cfg_r} < CW'(FRAMES)) ?
                     {{(CW-CFG_BITS){1'b0}}, cfg_r} : CW'(FRAMES);
  assign fr_ext    = CW'(fr_r);
  assign fr_bad    = (fr_ext >= eff);
  assign pt_idx    = {asid_r, vpn_r};
  assign scan_found = scan_pend_r && (pin_rdata_r == '0);
  assign scan_fail  = !scan_pend_r && (scan_addr_r >= eff);
  assign scan_issue = (state_r == S_SCAN) && !scan_found && (scan_addr_r < eff);
  assign clr_last   = (clr_r == CLRW'(CLR_DEPTH - 1));

  // Parallel tag compare with lowest-index priority.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    match_any = 1'b0;
    match_idx = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_tag_r[i] == vpn_r && tlb_space_r[i] == asid_r) begin
        match_any = 1'b1;
        match_idx = TW'(i);
        if (tlb_valid_r[i]) begin
          hit_any = 1'b1;
          hit_idx = TW'(i);
        end
      end
      if (!tlb_valid_r[i]) begin
        free_any = 1'b1;
        free_idx = TW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      S_CLEAR: begin
        if (clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (op_r) inside
          OP_TRANSLATE: state_nxt = hit_any ? S_IDLE : S_WALK;
          OP_PIN, OP_UNPIN: state_nxt = fr_bad ? S_IDLE : S_PIN;
          OP_SWITCH: state_nxt = S_SWITCH;
          OP_ALLOCATE: state_nxt = S_SCAN;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WALK: begin
        state_nxt = pt_rdata_r[FW] ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (scan_found || scan_fail) state_nxt = S_IDLE;
      end
      S_PIN, S_SWITCH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory accesses, buffer updates and results.
  always_comb begin
    pt_we = 1'b0; pt_re = 1'b0; pt_waddr = pt_idx; pt_raddr = pt_idx; pt_wdata = '0;
    pin_we = 1'b0; pin_re = 1'b0; pin_waddr = fr_ext[FW-1:0]; pin_wdata = '0;
    pin_raddr = fr_ext[FW-1:0];
    proc_we = 1'b0; proc_re = 1'b0; proc_waddr = pid_r; proc_raddr = pid_r;
    proc_wdata = next_id_r;
    scan_start = 1'b0;
    inval_all = 1'b0; inval_en = 1'b0; inval_idx = match_idx;
    fill_en = 1'b0; fill_frame = pt_rdata_r[FW-1:0];
    res_en = 1'b0; res_status = ST_OK; res_pa = '0; res_alloc = '0; res_pins = '0;
    next_id_nxt = next_id_r;
    cur_id_nxt = cur_id_r;
    unique case (state_r)
      S_CLEAR: begin
        pt_we = ({1'b0, clr_r} < (CLRW+1)'(TABLE_DEPTH));
        pt_waddr = clr_r[TIW-1:0];
        pin_we = ({1'b0, clr_r} < (CLRW+1)'(FRAMES));
        pin_waddr = clr_r[FW-1:0];
        proc_we = ({1'b0, clr_r} < (CLRW+1)'(NUM_SPACES));
        proc_waddr = clr_r[SPACE_BITS-1:0];
        proc_wdata = '0;
      end
      S_DECODE: begin
        unique case (op_r) inside
          OP_TRANSLATE: begin
            if (hit_any) begin
              res_en = 1'b1;
              res_pa = {10'(tlb_frame_r[hit_idx]), offset_r};
            end else begin
              pt_re = 1'b1;
            end
          end
          OP_FLUSH_ENTRY: begin
            res_en = 1'b1;
            inval_en = match_any;
            res_status = match_any ? ST_OK : ST_NO_ENTRY;
          end
          OP_FLUSH_ALL: begin
            res_en = 1'b1;
            inval_all = 1'b1;
          end
          OP_SWITCH: proc_re = 1'b1;
          OP_PIN, OP_UNPIN: begin
            if (fr_bad) begin
              res_en = 1'b1;
              res_status = ST_BAD_FRAME;
            end else begin
              pin_re = 1'b1;
            end
          end
          OP_ALLOCATE: scan_start = 1'b1;
          default: res_en = 1'b1;
        endcase
      end
      S_WALK: begin
        if (pt_rdata_r[FW]) begin
          fill_en = free_any;
          res_en = 1'b1;
          res_status = free_any ? ST_FILLED : ST_TLB_FULL;
          res_pa = {10'(pt_rdata_r[FW-1:0]), offset_r};
        end else begin
          scan_start = 1'b1;
        end
      end
      S_SCAN: begin
        pin_re = scan_issue;
        pin_raddr = scan_addr_r[FW-1:0];
        if (scan_found) begin
          pin_we = 1'b1;
          pin_waddr = scan_rd_r[FW-1:0];
          pin_wdata = PIN_BITS'(1);
          res_en = 1'b1;
          res_alloc = 10'(scan_rd_r);
          if (op_r == OP_TRANSLATE) begin
            pt_we = 1'b1;
            pt_wdata = {1'b1, scan_rd_r[FW-1:0]};
            fill_en = free_any;
            fill_frame = scan_rd_r[FW-1:0];
            res_status = free_any ? ST_FILLED : ST_TLB_FULL;
            res_pa = {10'(scan_rd_r), offset_r};
          end
        end else if (scan_fail) begin
          res_en = 1'b1;
          res_status = ST_NO_MEMORY;
        end
      end
      S_PIN: begin
        pin_we = 1'b1;
        res_en = 1'b1;
        if (op_r == OP_PIN) begin
          pin_wdata = (pin_rdata_r == PIN_MAX) ? pin_rdata_r : pin_rdata_r + 1'b1;
        end else if (pin_rdata_r == '0) begin
          res_status = ST_UNPINNED;
        end else begin
          pin_wdata = pin_rdata_r - 1'b1;
        end
        res_pins = pin_wdata;
      end
      S_SWITCH: begin
        res_en = 1'b1;
        if (proc_rdata_r == '0) begin
          proc_we = 1'b1;
          cur_id_nxt = next_id_r;
          next_id_nxt = next_id_r + 1'b1;
          if (next_id_nxt == '0) begin
            inval_all = 1'b1;
            next_id_nxt = SPACE_BITS'(1);
          end
        end else begin
          cur_id_nxt = proc_rdata_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      cfg_r <= CFG_RESET;
      next_id_r <= SPACE_BITS'(1);
      cur_id_r <= '0;
      out_valid_r <= 1'b0;
      scan_pend_r <= 1'b0;
      scan_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) cfg_r <= cfg_data;
      next_id_r <= next_id_nxt;
      cur_id_r <= cur_id_nxt;
      out_valid_r <= res_en;
      if (scan_start) begin
        scan_addr_r <= '0;
        scan_pend_r <= 1'b0;
      end else if (scan_issue) begin
        scan_addr_r <= scan_addr_r + 1'b1;
        scan_pend_r <= 1'b1;
      end else begin
        scan_pend_r <= 1'b0;
      end
    end
  end

  // Request capture, scan address tracking and result payload.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r <= in_operation;
      offset_r <= in_virtual_address[OFFSET_BITS-1:0];
      vpn_r <= va_ext[OFFSET_BITS +: PB];
      asid_r <= in_asid;
      pid_r <= in_process_id;
      fr_r <= in_frame_number;
    end
    if (scan_issue) scan_rd_r <= scan_addr_r;
    if (res_en) begin
      out_status_r <= res_status;
      out_pa_r <= res_pa;
      out_alloc_r <= res_alloc;
      out_pins_r <= res_pins;
      out_asid_r <= cur_id_nxt;
    end
  end

  // Buffer entries: valid bits and tags reset, fills and invalidations.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!rst_n) begin
        tlb_valid_r[i] <= 1'b0;
        tlb_tag_r[i] <= '0;
        tlb_frame_r[i] <= '0;
        tlb_space_r[i] <= '0;
      end else if (inval_all) begin
        tlb_valid_r[i] <= 1'b0;
      end else begin
        if (inval_en && inval_idx == TW'(i)) tlb_valid_r[i] <= 1'b0;
        if (fill_en && free_idx == TW'(i)) begin
          tlb_valid_r[i] <= 1'b1;
          tlb_tag_r[i] <= vpn_r;
          tlb_frame_r[i] <= fill_frame;
          tlb_space_r[i] <= asid_r;
        end
      end
    end
  end

  // Page table memory: present flag over frame number.
  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (pt_re) pt_rdata_r <= pt_mem[pt_raddr];
  end

  // Pin count memory.
  always_ff @(posedge clk) begin
    if (pin_we) pin_mem[pin_waddr] <= pin_wdata;
    if (pin_re) pin_rdata_r <= pin_mem[pin_raddr];
  end

  // Process to address space memory.
  always_ff @(posedge clk) begin
    if (proc_we) proc_mem[proc_waddr] <= proc_wdata;
    if (proc_re) proc_rdata_r <= proc_mem[proc_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_physical_address = out_pa_r;
  assign out_allocated_frame = out_alloc_r;
  assign out_pin_count_out = out_pins_r;
  assign out_current_asid_out = out_asid_r;

  // A result is only ever produced while a request is in progress.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

  // Every request that returns to idle leaves a result behind.
  a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r) != S_IDLE && $past(state_r) != S_CLEAR)
      |-> out_valid)
    else $error("request finished without a result");

  // An accepted request always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

  // The frame scan never runs past the usable frame count.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_addr_r <= eff))
    else $error("frame scan out of range");

endmodule

`default_nettype wire
